// ----- rtl/rar_pkg.sv -----
package rar_pkg;

  localparam int WORD_BITS = 32;
  localparam int MAG_BITS  = WORD_BITS + 1;
  localparam int CNT_BITS  = $clog2(MAG_BITS + 1);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [MAG_BITS-1:0] mag_t;

endpackage

// ----- rtl/rational_arith_reduce_unit.sv -----
// Rational arithmetic with gcd reduction.
//
// Input channel (in_valid / in_stall): command plus two fractions
// a_num/a_den and b_num/b_den. The result channel (out_valid / out_stall)
// returns res_num/res_den reduced by the gcd of their magnitudes, plus an
// overflow flag (a product or sum wrapped) and an undefined flag
// (unreduced numerator and denominator both zero, result 0/0).
//
// One request at a time. A single 32x32 multiplier forms the products in
// states MUL0 and MUL1 (multiply, divide) or MUL0 to MUL2 followed by the
// SUM state (add, subtract). A single restoring shift-subtract divider (one
// quotient bit per cycle) then runs the Euclidean remainder loop and
// finally the two exact divisions by the gcd; a 0/0 result skips the
// divisions. The count of remainder steps depends on the data (up to about
// 47). in_stall is high from acceptance until the result has been taken;
// the next request can be accepted in the cycle after that.
//
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid. While out_stall is high the result is held unchanged.
module rational_arith_reduce_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  input  logic signed [31:0]    in_a_num,
  input  logic signed [31:0]    in_a_den,
  input  logic signed [31:0]    in_b_num,
  input  logic signed [31:0]    in_b_den,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_res_num,
  output logic signed [31:0]    out_res_den,
  output logic                  out_overflow,
  output logic                  out_undefined
);
  import rar_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL0  = 9'b000000010,
    S_MUL1  = 9'b000000100,
    S_MUL2  = 9'b000001000,
    S_GCD   = 9'b000010000,
    S_DIVN  = 9'b000100000,
    S_DIVD  = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_SUM   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  cmd_t  cmd_r;
  word_t an_r, ad_r, bn_r, bd_r;
  word_t p1_r, num_r, den_r, rn_r;
  logic  ovf_r;

  // gcd / divider registers
  mag_t  x_r, y_r;          // Euclid operands (x mod y)
  mag_t  rem_r, quo_r, dvs_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic  div_busy_r;

  // shared multiplier
  word_t mul_a, mul_b;
  logic signed [2*WORD_BITS-1:0] prod;
  word_t prod_w;
  logic  prod_ovf;

  always_comb begin
    mul_a = an_r;
    mul_b = bd_r;
    case (state_r)
      S_MUL0: begin
        mul_a = an_r;
        mul_b = (cmd_r == CMD_MUL) ? bn_r : bd_r;
      end
      S_MUL1: begin
        mul_a = ad_r;
        mul_b = (cmd_r == CMD_DIV) ? bn_r : bd_r;
      end
      S_MUL2: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      default: begin
        mul_a = an_r;
        mul_b = bd_r;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_w   = prod[WORD_BITS-1:0];
  assign prod_ovf = (prod != {{WORD_BITS{prod_w[WORD_BITS-1]}}, prod_w});

  // sum/difference of p1 and p2 (p2 held in temp rn_r)
  logic signed [WORD_BITS:0] sum_ex;
  word_t sum_w;
  assign sum_ex = (cmd_r == CMD_ADD) ?
                  ({p1_r[WORD_BITS-1], p1_r} + {rn_r[WORD_BITS-1], rn_r}) :
                  ({p1_r[WORD_BITS-1], p1_r} - {rn_r[WORD_BITS-1], rn_r});
  assign sum_w  = sum_ex[WORD_BITS-1:0];

  function automatic mag_t mag_of(word_t v);
    logic [WORD_BITS-1:0] n;
    n = -v;
    return v[WORD_BITS-1] ? {1'b0, n} : {1'b0, v};
  endfunction

  // one restoring division step
  mag_t rem_sh, rem_sub;
  logic rem_ge;
  assign rem_sh  = {rem_r[MAG_BITS-2:0], quo_r[MAG_BITS-1]};
  assign rem_ge  = ({1'b0, rem_sh} >= {1'b0, dvs_r});
  assign rem_sub = rem_ge ? (rem_sh - dvs_r) : rem_sh;

  logic div_last;
  assign div_last = (cnt_r == CNT_BITS'(MAG_BITS - 1));

  logic is_neg_num;
  word_t q_next_mag, q_signed;
  assign q_next_mag = word_t'({quo_r[MAG_BITS-3:0], rem_ge});
  assign q_signed   = is_neg_num ? -q_next_mag : q_next_mag;
  assign is_neg_num = (state_r == S_DIVN) ? num_r[WORD_BITS-1] : den_r[WORD_BITS-1];

  logic out_valid_r;
  word_t res_num_r, res_den_r;
  logic undef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      div_busy_r  <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= cmd_t'(in_command);
            an_r  <= in_a_num[WORD_BITS-1:0];
            ad_r  <= in_a_den[WORD_BITS-1:0];
            bn_r  <= in_b_num[WORD_BITS-1:0];
            bd_r  <= in_b_den[WORD_BITS-1:0];
            ovf_r <= 1'b0;
          end
        end
        S_MUL0: begin
          p1_r  <= prod_w;
          num_r <= prod_w;
          ovf_r <= ovf_r | prod_ovf;
        end
        S_MUL1: begin
          den_r <= prod_w;
          ovf_r <= ovf_r | prod_ovf;
        end
        S_MUL2: begin
          rn_r  <= prod_w;
          ovf_r <= ovf_r | prod_ovf;
        end
        S_SUM: begin
          num_r <= sum_w;
          if (sum_ex != {sum_w[WORD_BITS-1], sum_w}) ovf_r <= 1'b1;
        end
        S_GCD: begin
          if (!div_busy_r) begin
            if (y_r != '0) begin
              rem_r      <= '0;
              quo_r      <= x_r;
              dvs_r      <= y_r;
              cnt_r      <= '0;
              div_busy_r <= 1'b1;
            end else begin
              // x_r holds the gcd; start numerator division unless the gcd is zero
              rem_r      <= '0;
              quo_r      <= mag_of(num_r);
              dvs_r      <= x_r;
              cnt_r      <= '0;
              div_busy_r <= (x_r != '0);
              undef_r    <= (x_r == '0);
            end
          end else begin
            rem_r <= rem_sub;
            quo_r <= {quo_r[MAG_BITS-2:0], rem_ge};
            cnt_r <= cnt_r + 1'b1;
            if (div_last) begin
              x_r        <= y_r;
              y_r        <= rem_sub;
              div_busy_r <= 1'b0;
            end
          end
        end
        S_DIVN, S_DIVD: begin
          rem_r <= rem_sub;
          quo_r <= {quo_r[MAG_BITS-2:0], rem_ge};
          cnt_r <= cnt_r + 1'b1;
          if (div_last) begin
            cnt_r <= '0;
            rem_r <= '0;
            quo_r <= mag_of(den_r);
            if (state_r == S_DIVN) rn_r <= q_signed;
            else begin
              res_num_r   <= rn_r;
              res_den_r   <= q_signed;
              out_valid_r <= 1'b1;
              div_busy_r  <= 1'b0;
            end
          end
        end
        S_OUT: ;
        default: ;
      endcase
      if (state_r == S_GCD && state_nxt == S_OUT) begin
        res_num_r   <= '0;
        res_den_r   <= '0;
        out_valid_r <= 1'b1;
      end
      // load Euclid operands once products are final
      if ((state_r == S_MUL1 && cmd_r[1]) ) begin
        x_r <= mag_of(num_r);
        y_r <= mag_of(prod_w);
      end
      if (state_r == S_SUM) begin
        x_r <= mag_of(sum_w);
        y_r <= mag_of(den_r);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MUL0;
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: state_nxt = cmd_r[1] ? S_GCD : S_MUL2;
      S_MUL2: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_GCD;
      S_GCD: begin
        if (!div_busy_r && y_r == '0)
          state_nxt = (x_r == '0) ? S_OUT : S_DIVN;
      end
      S_DIVN: if (div_last) state_nxt = S_DIVD;
      S_DIVD: if (div_last) state_nxt = S_OUT;
      S_OUT:  if (out_valid_r && !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_res_num   = 32'(res_num_r);
  assign out_res_den   = 32'(res_den_r);
  assign out_overflow  = ovf_r;
  assign out_undefined = undef_r;

  a_result_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT)
    else $error("result shown outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input open while busy");
  a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy_r |-> cnt_r <= CNT_BITS'(MAG_BITS - 1))
    else $error("divider count overrun");
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_undefined) |-> (out_res_num == 0 && out_res_den == 0))
    else $error("undefined result not 0/0");

endmodule

// ----- tb/rational_arith_reduce_unit_tb.sv -----
`timescale 1ns / 1ps

module rational_arith_reduce_unit_tb;
  import rar_pkg::*;

  // One request on the input channel; drain means "wait for all results first".
  typedef struct {
    cmd_t  cmd;
    word_t an;
    word_t ad;
    word_t bn;
    word_t bd;
    bit    drain;
  } frac_req_t;

  // One reduced fraction as the block should return it.
  typedef struct {
    word_t num;
    word_t den;
    bit    ovf;
    bit    undef;
  } frac_res_t;

  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int     HOLD_CYCLES = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic signed [31:0] in_a_num = '0;
  logic signed [31:0] in_a_den = '0;
  logic signed [31:0] in_b_num = '0;
  logic signed [31:0] in_b_den = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [31:0] out_res_num;
  logic signed [31:0] out_res_den;
  logic        out_overflow;
  logic        out_undefined;

  frac_req_t pend_q[$];    // requests not yet offered
  frac_res_t reduced_q[$]; // expected fractions, oldest first
  frac_req_t cur_req;
  int        mismatches = 0;
  longint    cycles = 0;
  bit        gen_done = 1'b0;

  rational_arith_reduce_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_a_num     (in_a_num),
    .in_a_den     (in_a_den),
    .in_b_num     (in_b_num),
    .in_b_den     (in_b_den),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res_num  (out_res_num),
    .out_res_den  (out_res_den),
    .out_overflow (out_overflow),
    .out_undefined(out_undefined)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Wrap an exact value to the 32-bit word, flag any change.
  function automatic longint wrap_word(longint exact, inout bit ovf);
    word_t w;
    w = exact[31:0];
    if (longint'(w) != exact) ovf = 1'b1;
    return longint'(w);
  endfunction

  // Form the products (and the sum or difference), then divide both parts by gcd(|num|, |den|); 0/0 is undefined.
  function automatic frac_res_t reduce_fraction(frac_req_t r);
    frac_res_t res;
    longint an, ad, bn, bd, p1, p2, num, den;
    longint unsigned x, y, t;
    bit ovf;
    an = r.an; ad = r.ad; bn = r.bn; bd = r.bd;
    ovf = 1'b0;
    case (r.cmd)
      CMD_ADD, CMD_SUB: begin
        p1  = wrap_word(an * bd, ovf);
        p2  = wrap_word(bn * ad, ovf);
        den = wrap_word(ad * bd, ovf);
        num = wrap_word((r.cmd == CMD_ADD) ? p1 + p2 : p1 - p2, ovf);
      end
      CMD_MUL: begin
        num = wrap_word(an * bn, ovf);
        den = wrap_word(ad * bd, ovf);
      end
      default: begin
        num = wrap_word(an * bd, ovf);
        den = wrap_word(ad * bn, ovf);
      end
    endcase
    x = (num < 0) ? longint'(-num) : num;
    y = (den < 0) ? longint'(-den) : den;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    res.ovf = ovf;
    if (x == 0) begin
      res.num = '0;
      res.den = '0;
      res.undef = 1'b1;
    end else begin
      res.num = num / longint'(x);
      res.den = den / longint'(x);
      res.undef = 1'b0;
    end
    return res;
  endfunction

  // Operand mix: extremes, small values (short gcd runs) and full-range words.
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sd0;
          3: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return word_t'($urandom);
      4, 5: return word_t'($signed($urandom_range(0, 131070)) - 65535);
      default: return word_t'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  task automatic add_req(cmd_t c, word_t an, word_t ad, word_t bn, word_t bd, bit drain);
    frac_req_t r;
    r.cmd = c; r.an = an; r.ad = ad; r.bn = bn; r.bd = bd; r.drain = drain;
    pend_q.push_back(r);
  endtask

  // Stimulus: directed corners first, then random requests.
  initial begin
    frac_req_t r;
    add_req(CMD_ADD, 1, 2, 1, 3, 0);
    add_req(CMD_SUB, 1, 2, 1, 2, 0);                    // zero over nonzero
    add_req(CMD_MUL, 6, 4, 10, 15, 0);
    add_req(CMD_DIV, 3, 7, 9, 14, 0);
    add_req(CMD_ADD, 5, 0, 7, 0, 0);                    // both parts zero
    add_req(CMD_MUL, 0, 0, 3, 5, 0);                    // both parts zero
    add_req(CMD_DIV, 5, 3, 0, 1, 0);                    // zero den, pos num
    add_req(CMD_DIV, -5, 3, 0, 2, 0);                   // zero den, neg num
    add_req(CMD_MUL, -3, -4, 2, 1, 0);                  // negative den kept
    add_req(CMD_MUL, 32'sh8000_0000, 1, 1, 1, 0);       // most negative word
    add_req(CMD_MUL, 32'sh8000_0000, 32'sh8000_0000, 1, 1, 0);
    add_req(CMD_ADD, 32'sh8000_0000, 1, 32'sh8000_0000, 1, 0);
    add_req(CMD_SUB, 32'sh7fff_ffff, 1, 32'sh8000_0000, 1, 0);
    add_req(CMD_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
    add_req(CMD_DIV, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 0);
    add_req(CMD_ADD, 65536, 65536, 65536, 65536, 0);    // overflow on products
    add_req(CMD_DIV, -1, -1, -1, -1, 0);
    add_req(CMD_SUB, 0, 0, 0, 0, 0);
    add_req(CMD_MUL, 32'shffff_ffff, 32'sh0000_0001, 32'shaaaa_aaaa, 32'sh5555_5555, 0);
    add_req(CMD_ADD, 32'sh1234_5678, 32'sh7654_3210, 32'shdead_beef, 32'shcafe_f00d, 0);
    for (int i = 0; i < 1200; i++) begin
      r.cmd = cmd_t'($urandom_range(0, 3));
      r.an = pick_word();
      r.ad = pick_word();
      r.bn = pick_word();
      r.bd = pick_word();
      // mostly well-formed fractions, nonzero denominators
      if ($urandom_range(0, 9) != 0) begin
        if (r.ad == 0) r.ad = 1;
        if (r.bd == 0) r.bd = -1;
      end
      r.drain = (i == 600);
      pend_q.push_back(r);
    end
    gen_done = 1'b1;
  end

  // Driver: bursts of requests with random gaps; payload held while stalled.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n && gen_done) begin
      if (in_valid && !in_stall)
        reduced_q.push_back(reduce_fraction(cur_req));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pend_q.size() != 0 &&
                     !(pend_q[0].drain && (reduced_q.size() != 0 || in_valid))) begin
          cur_req = pend_q.pop_front();
          in_valid   <= 1'b1;
          in_command <= cur_req.cmd;
          in_a_num   <= cur_req.an;
          in_a_den   <= cur_req.ad;
          in_b_num   <= cur_req.bn;
          in_b_den   <= cur_req.bd;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 30);
            // a third of bursts run back to back
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern plus one long hold-off to back up the input.
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  taken = 0;
  int  mode = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) taken <= taken + 1;
      if ($urandom_range(0, 199) == 0) mode <= $urandom_range(0, 3);
      if (!hold_done && taken == 300) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Monitor: compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    frac_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (reduced_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d/%0d ovf=%0b undef=%0b",
                   out_res_num, out_res_den, out_overflow, out_undefined);
      end else begin
        e = reduced_q.pop_front();
        if (out_res_num !== e.num || out_res_den !== e.den ||
            out_overflow !== e.ovf || out_undefined !== e.undef) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d ovf=%0b undef=%0b, got %0d/%0d ovf=%0b undef=%0b",
                     e.num, e.den, e.ovf, e.undef,
                     out_res_num, out_res_den, out_overflow, out_undefined);
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Reset, then wait for all requests and results, then settle.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (gen_done);
    @(posedge clk);
    while (pend_q.size() != 0 || in_valid || reduced_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && reduced_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rar_pkg.sv
rtl/rational_arith_reduce_unit.sv
tb/rational_arith_reduce_unit_tb.sv
